/* rtl/core/gec_pkg.sv */
// Shared widths, types and helper function of the Golomb encoder.
package gec_pkg;

  // Fixed field widths of the sample, divisor and code channels.
  localparam int DataBits         = 16;
  localparam int SuffixBits       = 17;
  localparam int LenBits          = 5;
  localparam int ValueBitsDefault = 16;

  // Payload handed from one divider cell to the next.
  typedef struct packed {
    logic [DataBits-1:0] rem;   // partial remainder, always below the divisor
    logic [DataBits-1:0] val;   // dividend bits still to be consumed, left aligned
    logic [DataBits-1:0] quot;  // quotient bits produced so far
  } stage_t;

  // Code parameters derived from the divisor.
  typedef struct packed {
    logic                  pow2;  // divisor is a power of two
    logic [LenBits-1:0]    bits;  // ceil(log2(divisor))
    logic [SuffixBits-1:0] unused_codes; // 2^bits - divisor
  } enc_cfg_t;

  // Ceiling of log2 for a non-zero divisor: width of (m - 1).
  function automatic logic [LenBits-1:0] ceil_log2(input logic [DataBits-1:0] m);
    logic [DataBits-1:0] mm1;
    logic [LenBits-1:0]  b;
    mm1 = m - DataBits'(1);
    b   = '0;
    for (int i = 0; i < DataBits; i++) begin
      if (mm1[i]) begin
        b = LenBits'(i + 1);
      end
    end
    return b;
  endfunction

endpackage

/* rtl/core/gec_sample_if.sv */
// Stream interface carrying one sample value per transfer.
interface gec_sample_if;
  logic                         valid;
  logic                         ready;
  logic [gec_pkg::DataBits-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

/* rtl/core/gec_code_if.sv */
// Stream interface carrying one Golomb code word per transfer.
interface gec_code_if;
  logic                           valid;
  logic                           ready;
  logic [gec_pkg::DataBits-1:0]   zero_count;
  logic [gec_pkg::SuffixBits-1:0] suffix_bits;
  logic [gec_pkg::LenBits-1:0]    suffix_length;

  modport source (output valid, output zero_count, output suffix_bits,
                  output suffix_length, input ready);
  modport sink (input valid, input zero_count, input suffix_bits,
                input suffix_length, output ready);
endinterface

/* rtl/core/gec_div_cell.sv */
// One restoring division cell: produces a single quotient bit per item.
module gec_div_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [gec_pkg::DataBits-1:0] divisor_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gec_pkg::stage_t              in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output gec_pkg::stage_t              out_data_o
);

  logic                           valid_q;
  gec_pkg::stage_t                data_q, data_d;
  logic [gec_pkg::DataBits:0]     trial;
  logic [gec_pkg::DataBits:0]     diff;
  logic                           fits;

  // Bring down the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    trial       = {in_data_i.rem, in_data_i.val[gec_pkg::DataBits-1]};
    diff        = trial - {1'b0, divisor_i};
    fits        = (trial >= {1'b0, divisor_i});
    data_d.rem  = fits ? diff[gec_pkg::DataBits-1:0] : trial[gec_pkg::DataBits-1:0];
    data_d.val  = {in_data_i.val[gec_pkg::DataBits-2:0], 1'b0};
    data_d.quot = {in_data_i.quot[gec_pkg::DataBits-2:0], fits};
  end

  // The cell takes a new transfer when it is empty or its content moves on.
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* rtl/core/gec_suffix_stage.sv */
// Final stage: forms the remainder code and holds the result for the sink.
module gec_suffix_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gec_pkg::enc_cfg_t     cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gec_pkg::stage_t       in_data_i,
  gec_code_if.source            code_o
);

  logic                           valid_q;
  logic [gec_pkg::DataBits-1:0]   quot_q;
  logic [gec_pkg::SuffixBits-1:0] suffix_q, suffix_d;
  logic [gec_pkg::LenBits-1:0]    len_q, len_d;
  logic [gec_pkg::SuffixBits-1:0] rem_ext;
  logic [gec_pkg::SuffixBits-1:0] top_one;
  logic [gec_pkg::SuffixBits-1:0] short_one;

  // Truncated binary code; a power-of-two divisor takes the plain form.
  always_comb begin
    rem_ext   = {1'b0, in_data_i.rem};
    top_one   = gec_pkg::SuffixBits'(1) << cfg_i.bits;
    short_one = top_one >> 1;
    if (cfg_i.pow2) begin
      suffix_d = top_one | rem_ext;
      len_d    = cfg_i.bits + gec_pkg::LenBits'(1);
    end else if (rem_ext < cfg_i.unused_codes) begin
      suffix_d = short_one | rem_ext;
      len_d    = cfg_i.bits;
    end else begin
      suffix_d = top_one | (rem_ext + cfg_i.unused_codes);
      len_d    = cfg_i.bits + gec_pkg::LenBits'(1);
    end
  end

  // Output register parts the divider chain from the sink.
  assign in_ready_o = !valid_q || code_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      quot_q   <= in_data_i.quot;
      suffix_q <= suffix_d;
      len_q    <= len_d;
    end
  end

  assign code_o.valid         = valid_q;
  assign code_o.zero_count    = quot_q;
  assign code_o.suffix_bits   = suffix_q;
  assign code_o.suffix_length = len_q;

endmodule

/* rtl/core/golomb_encoder_unit.sv */
// Golomb encoder top level: divisor register, divider cell chain and code stage.
// A sample accepted by the chain passes through the register of each cell, one cell
// per quotient bit, and then the code stage register before it leaves as a code word.
// Throughput: one sample per cycle while the sink is ready; a full cell holds its content while the next one stalls.
// Reset (asynchronous, active low) empties all cells and sets the divisor to one.
// A divisor of zero is stored as one.
module golomb_encoder_unit #(
  parameter int VALUE_BITS = gec_pkg::ValueBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         golomb_divisor_we_i,
  input  logic [gec_pkg::DataBits-1:0] golomb_divisor_i,
  gec_sample_if.sink                   sample_i,
  gec_code_if.source                   code_o
);

  // Only the low bits of the sample that both widths allow take part.
  localparam int NumCells = (VALUE_BITS < gec_pkg::DataBits) ? VALUE_BITS
                                                              : gec_pkg::DataBits;
  localparam int AlignShift = gec_pkg::DataBits - NumCells;

  logic [gec_pkg::DataBits-1:0] divisor_q, divisor_d;
  gec_pkg::enc_cfg_t            cfg_q, cfg_d;

  logic            cell_valid [NumCells+1];
  logic            cell_ready [NumCells+1];
  gec_pkg::stage_t cell_data  [NumCells+1];

  // Divisor register; zero behaves as one.
  assign divisor_d = (golomb_divisor_i == '0) ? gec_pkg::DataBits'(1) : golomb_divisor_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= gec_pkg::DataBits'(1);
    end else if (golomb_divisor_we_i) begin
      divisor_q <= divisor_d;
    end
  end

  // Code parameters are registered from the divisor and follow it in the next cycle,
  // before any item divided by the new divisor can reach the code stage.
  always_comb begin
    cfg_d.pow2         = ((divisor_q & (divisor_q - gec_pkg::DataBits'(1))) == '0);
    cfg_d.bits         = gec_pkg::ceil_log2(divisor_q);
    cfg_d.unused_codes = (gec_pkg::SuffixBits'(1) << cfg_d.bits) - {1'b0, divisor_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pow2: 1'b1, bits: '0, unused_codes: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Entry of the chain: dividend left aligned, remainder and quotient cleared.
  assign cell_valid[0]     = sample_i.valid;
  assign sample_i.ready    = cell_ready[0];
  assign cell_data[0].rem  = '0;
  assign cell_data[0].val  = sample_i.sample_value << AlignShift;
  assign cell_data[0].quot = '0;

  // One division cell per quotient bit, most significant first.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    gec_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .divisor_i   (divisor_q),
      .in_valid_i  (cell_valid[k]),
      .in_ready_o  (cell_ready[k]),
      .in_data_i   (cell_data[k]),
      .out_valid_o (cell_valid[k+1]),
      .out_ready_i (cell_ready[k+1]),
      .out_data_o  (cell_data[k+1])
    );
  end

  // Remainder code and output register.
  gec_suffix_stage u_suffix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (cell_valid[NumCells]),
    .in_ready_o (cell_ready[NumCells]),
    .in_data_i  (cell_data[NumCells]),
    .code_o     (code_o)
  );

endmodule
